@@ src/aro_pkg.sv @@
// ----------------------------------------------------------------------------
// aro_pkg
// shared types, widths and the cordic arctangent table
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package aro_pkg;

  localparam int CoordW   = 20;
  localparam int DiffW    = 21;
  localparam int EntryW   = 16;
  localparam int RowW     = 48;
  localparam int PivotW   = 60;
  localparam int CfgW     = 60;
  localparam int CfgIdxW  = 3;
  localparam int AngleW   = 16;
  localparam int CxW      = 20;
  localparam int CzW      = 26;
  localparam int AtanW    = 22;
  localparam int TrigW    = 17;
  localparam int Steps    = 16;
  localparam int StepW    = 4;
  localparam int RowDepth = 5;
  localparam int Depth    = 2 + Steps + RowDepth;

  localparam logic [CfgIdxW-1:0] RegOuter0 = 3'd0;
  localparam logic [CfgIdxW-1:0] RegOuter1 = 3'd1;
  localparam logic [CfgIdxW-1:0] RegOuter2 = 3'd2;
  localparam logic [CfgIdxW-1:0] RegCross0 = 3'd3;
  localparam logic [CfgIdxW-1:0] RegCross1 = 3'd4;
  localparam logic [CfgIdxW-1:0] RegCross2 = 3'd5;
  localparam logic [CfgIdxW-1:0] RegPivot  = 3'd6;

  localparam logic signed [CxW-1:0] CordicX0 = 20'sd39797;

  typedef struct packed {
    logic signed [CxW-1:0]   x;
    logic signed [CxW-1:0]   y;
    logic signed [CzW-1:0]   z;
    logic                    neg;
    logic signed [DiffW-1:0] d0;
    logic signed [DiffW-1:0] d1;
    logic signed [DiffW-1:0] d2;
  } cordic_t;

  function automatic logic [AtanW-1:0] atan_val(input logic [StepW-1:0] i);
    logic [AtanW-1:0] v;
    case (i)
      4'd0:    v = 22'd2097152;
      4'd1:    v = 22'd1238021;
      4'd2:    v = 22'd654136;
      4'd3:    v = 22'd332050;
      4'd4:    v = 22'd166669;
      4'd5:    v = 22'd83416;
      4'd6:    v = 22'd41718;
      4'd7:    v = 22'd20860;
      4'd8:    v = 22'd10430;
      4'd9:    v = 22'd5215;
      4'd10:   v = 22'd2608;
      4'd11:   v = 22'd1304;
      4'd12:   v = 22'd652;
      4'd13:   v = 22'd326;
      4'd14:   v = 22'd163;
      4'd15:   v = 22'd81;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

@@ src/axis_rotation_of_point.sv @@
// ----------------------------------------------------------------------------
// axis_rotation_of_point
// rotates a Q12.8 point about a configured axis through a configured pivot
// ----------------------------------------------------------------------------
// A fully pipelined datapath that takes one transaction per clock while
// in_ready_o is high and returns one result transaction per input, in order,
// through 23 register stages, the first of which captures the transaction at
// the accepting edge: one input register stage, a chain of 16 cordic cells
// producing sine and cosine, one rounding stage, and a five-stage row cell per
// coordinate (matrix products, row sums, split partial products, final sum,
// round/add pivot/saturate). The whole pipeline advances together: in_ready_o
// is high whenever the last stage is empty or the downstream side takes its
// result, so throughput is one per cycle. Configuration registers (outer rows,
// cross rows, pivot) are written through the cfg port and must only change
// while no transaction is in flight.
`timescale 1ns / 1ps
`default_nettype none

module axis_rotation_of_point import aro_pkg::*; (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire logic [CfgIdxW-1:0]       cfg_index_i,
  input  wire logic [CfgW-1:0]          cfg_wdata_i,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic signed [CoordW-1:0] point_x_i,
  input  wire logic signed [CoordW-1:0] point_y_i,
  input  wire logic signed [CoordW-1:0] point_z_i,
  input  wire logic [AngleW-1:0]        turn_angle_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic signed [CoordW-1:0]      rotated_x_o,
  output logic signed [CoordW-1:0]      rotated_y_o,
  output logic signed [CoordW-1:0]      rotated_z_o
);

  // configuration registers
  logic [RowW-1:0]   outer_q [3];
  logic [RowW-1:0]   cross_q [3];
  logic [PivotW-1:0] pivot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < 3; r++) begin
        outer_q[r] <= '0;
        cross_q[r] <= '0;
      end
      pivot_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegOuter0: outer_q[0] <= cfg_wdata_i[RowW-1:0];
        RegOuter1: outer_q[1] <= cfg_wdata_i[RowW-1:0];
        RegOuter2: outer_q[2] <= cfg_wdata_i[RowW-1:0];
        RegCross0: cross_q[0] <= cfg_wdata_i[RowW-1:0];
        RegCross1: cross_q[1] <= cfg_wdata_i[RowW-1:0];
        RegCross2: cross_q[2] <= cfg_wdata_i[RowW-1:0];
        RegPivot:  pivot_q    <= cfg_wdata_i[PivotW-1:0];
        default:   ;
      endcase
    end
  end

  logic signed [CoordW-1:0] piv [3];
  assign piv[0] = $signed(pivot_q[19:0]);
  assign piv[1] = $signed(pivot_q[39:20]);
  assign piv[2] = $signed(pivot_q[59:40]);

  // pipeline control: every stage moves when the last one can drain
  logic [Depth-1:0] vld_q, vld_d;
  logic             en;

  assign en          = !vld_q[Depth-1] || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = vld_q[Depth-1];

  always_comb begin
    vld_d = {vld_q[Depth-2:0], in_valid_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= vld_d;
    end
  end

  // input stage: fold the angle into the right half plane, take d = p - pivot
  logic [1:0]        quad;
  logic              fold;
  logic [AngleW-1:0] ang;
  cordic_t           in_s, s0_q;

  always_comb begin
    quad    = turn_angle_i[15:14];
    fold    = (quad == 2'b01) || (quad == 2'b10);
    ang     = fold ? (turn_angle_i - 16'h8000) : turn_angle_i;
    in_s.x  = CordicX0;
    in_s.y  = '0;
    in_s.z  = CzW'($signed({ang, 8'd0}));
    in_s.neg = fold;
    in_s.d0 = DiffW'(point_x_i) - DiffW'(piv[0]);
    in_s.d1 = DiffW'(point_y_i) - DiffW'(piv[1]);
    in_s.d2 = DiffW'(point_z_i) - DiffW'(piv[2]);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_q <= in_s;
    end
  end

  // cordic chain
  cordic_t chain [Steps+1];
  assign chain[0] = s0_q;

  for (genvar i = 0; i < Steps; i++) begin : g_cordic
    aro_cordic_cell u_cell (
      .clk_i  (clk_i),
      .en_i   (en),
      .step_i (StepW'(i)),
      .s_i    (chain[i]),
      .s_o    (chain[i+1])
    );
  end

  // round sine/cosine to Q2.14, clamp, undo the fold
  cordic_t cend;
  logic signed [CxW-1:0]   xr, yr;
  logic signed [TrigW-1:0] cs_d, sn_d, cs_q, sn_q;
  logic signed [DiffW-1:0] dq [3];

  assign cend = chain[Steps];

  always_comb begin
    xr = (cend.x + CxW'(2)) >>> 2;
    yr = (cend.y + CxW'(2)) >>> 2;
    if (xr > CxW'(16384)) begin
      cs_d = 17'sd16384;
    end else if (xr < -CxW'(16384)) begin
      cs_d = -17'sd16384;
    end else begin
      cs_d = xr[TrigW-1:0];
    end
    if (yr > CxW'(16384)) begin
      sn_d = 17'sd16384;
    end else if (yr < -CxW'(16384)) begin
      sn_d = -17'sd16384;
    end else begin
      sn_d = yr[TrigW-1:0];
    end
    if (cend.neg) begin
      cs_d = -cs_d;
      sn_d = -sn_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cs_q  <= cs_d;
      sn_q  <= sn_d;
      dq[0] <= cend.d0;
      dq[1] <= cend.d1;
      dq[2] <= cend.d2;
    end
  end

  // one row cell per output coordinate
  logic signed [CoordW-1:0] res [3];

  for (genvar r = 0; r < 3; r++) begin : g_row
    aro_row_cell u_row (
      .clk_i   (clk_i),
      .en_i    (en),
      .cs_i    (cs_q),
      .sn_i    (sn_q),
      .d0_i    (dq[0]),
      .d1_i    (dq[1]),
      .d2_i    (dq[2]),
      .dself_i (dq[r]),
      .outer_i (outer_q[r]),
      .cross_i (cross_q[r]),
      .pivot_i (piv[r]),
      .res_o   (res[r])
    );
  end

  assign rotated_x_o = res[0];
  assign rotated_y_o = res[1];
  assign rotated_z_o = res[2];

  // ready follows the drain condition of the last stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == (!out_valid_o || out_ready_i))
    else $error("ready does not follow pipeline drain");

  // an accepted transaction enters the first stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> vld_q[0])
    else $error("accepted transaction lost at entry");

  // a stalled result stays valid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o)
    else $error("stalled result dropped");

  // stages advance in lockstep
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && vld_q[Steps]) |=> vld_q[Steps+1])
    else $error("pipeline valid chain broken");

endmodule

`default_nettype wire

@@ src/aro_cordic_cell.sv @@
// ----------------------------------------------------------------------------
// aro_cordic_cell
// one rotation step of the sine/cosine chain, carrying the point difference
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module aro_cordic_cell import aro_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             en_i,
  input  wire logic [StepW-1:0] step_i,
  input  wire cordic_t          s_i,
  output cordic_t               s_o
);

  cordic_t s_d, s_q;
  logic signed [CxW-1:0] xs, ys;
  logic signed [CzW-1:0] at;

  always_comb begin
    xs  = s_i.x >>> step_i;
    ys  = s_i.y >>> step_i;
    at  = $signed(CzW'(atan_val(step_i)));
    s_d = s_i;
    if (!s_i.z[CzW-1]) begin
      s_d.x = s_i.x - ys;
      s_d.y = s_i.y + xs;
      s_d.z = s_i.z - at;
    end else begin
      s_d.x = s_i.x + ys;
      s_d.y = s_i.y - xs;
      s_d.z = s_i.z + at;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s_q <= s_d;
    end
  end

  assign s_o = s_q;

endmodule

`default_nettype wire

@@ src/aro_row_cell.sv @@
// ----------------------------------------------------------------------------
// aro_row_cell
// one output coordinate: matrix row products, rodrigues sum, round, saturate
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module aro_row_cell import aro_pkg::*; (
  input  wire logic                     clk_i,
  input  wire logic                     en_i,
  input  wire logic signed [TrigW-1:0]  cs_i,
  input  wire logic signed [TrigW-1:0]  sn_i,
  input  wire logic signed [DiffW-1:0]  d0_i,
  input  wire logic signed [DiffW-1:0]  d1_i,
  input  wire logic signed [DiffW-1:0]  d2_i,
  input  wire logic signed [DiffW-1:0]  dself_i,
  input  wire logic [RowW-1:0]          outer_i,
  input  wire logic [RowW-1:0]          cross_i,
  input  wire logic signed [CoordW-1:0] pivot_i,
  output logic signed [CoordW-1:0]      res_o
);

  localparam int PW = EntryW + DiffW;
  localparam int SW = PW + 2;
  localparam int HW = SW - 19;
  localparam int MW = TrigW + DiffW;
  localparam int QW = 18 + HW;
  localparam int AW = 60;

  // stage 1: products
  logic signed [PW-1:0] p1_q [3];
  logic signed [PW-1:0] p2_q [3];
  logic signed [TrigW-1:0] cs1_q, sn1_q;
  logic signed [DiffW-1:0] ds1_q;
  // stage 2: row sums
  logic signed [SW-1:0] b_q, e_q;
  logic signed [MW-1:0] cd_q;
  logic signed [17:0]   c1_q;
  logic signed [TrigW-1:0] sn2_q;
  // stage 3: partial products
  logic signed [MW-1:0] cd3_q;
  logic signed [QW-1:0] t1h_q, t1l_q, t2h_q, t2l_q;
  // stage 4: sum
  logic signed [AW-1:0] sum_q;
  // stage 5: result
  logic signed [CoordW-1:0] res_q;

  logic signed [DiffW-1:0] dv [3];
  logic signed [AW-1:0] rnd;
  logic signed [31:0]   sh;
  logic signed [33:0]   res;
  logic signed [CoordW-1:0] res_d;

  assign dv[0] = d0_i;
  assign dv[1] = d1_i;
  assign dv[2] = d2_i;

  always_comb begin
    rnd = sum_q + AW'(64'sd134217728);
    sh  = rnd[AW-1:28];
    res = 34'(sh) + 34'(pivot_i);
    if (res > 34'sd524287) begin
      res_d = 20'sd524287;
    end else if (res < -34'sd524288) begin
      res_d = -20'sd524288;
    end else begin
      res_d = res[CoordW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        p1_q[k] <= $signed(outer_i[EntryW*k +: EntryW]) * dv[k];
        p2_q[k] <= $signed(cross_i[EntryW*k +: EntryW]) * dv[k];
      end
      cs1_q <= cs_i;
      sn1_q <= sn_i;
      ds1_q <= dself_i;

      b_q   <= SW'(p1_q[0]) + SW'(p1_q[1]) + SW'(p1_q[2]);
      e_q   <= SW'(p2_q[0]) + SW'(p2_q[1]) + SW'(p2_q[2]);
      cd_q  <= cs1_q * ds1_q;
      c1_q  <= 18'sd16384 - 18'(cs1_q);
      sn2_q <= sn1_q;

      cd3_q <= cd_q;
      t1h_q <= QW'(c1_q) * QW'($signed(b_q[SW-1:19]));
      t1l_q <= QW'(c1_q) * QW'($signed({1'b0, b_q[18:0]}));
      t2h_q <= QW'(sn2_q) * QW'($signed(e_q[SW-1:19]));
      t2l_q <= QW'(sn2_q) * QW'($signed({1'b0, e_q[18:0]}));

      sum_q <= (AW'(cd3_q) <<< 14) + (AW'(t1h_q) <<< 19) + AW'(t1l_q)
             + (AW'(t2h_q) <<< 19) + AW'(t2l_q);

      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

`default_nettype wire

@@ tb/aro_checker.sv @@
// ----------------------------------------------------------------------------
// aro_checker
// predicts each rotated point and compares it with the result channel
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aro_checker import aro_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CfgIdxW-1:0]       cfg_index_i,
  input  logic [CfgW-1:0]          cfg_wdata_i,
  input  logic                     in_valid_i,
  input  logic                     in_ready_i,
  input  logic signed [CoordW-1:0] point_x_i,
  input  logic signed [CoordW-1:0] point_y_i,
  input  logic signed [CoordW-1:0] point_z_i,
  input  logic [AngleW-1:0]        turn_angle_i,
  input  logic                     out_valid_i,
  input  logic                     out_ready_i,
  input  logic signed [CoordW-1:0] rotated_x_i,
  input  logic signed [CoordW-1:0] rotated_y_i,
  input  logic signed [CoordW-1:0] rotated_z_i,
  output int                       fail_count_o,
  output int                       pending_o
);

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] z;
  } point_t;

  logic [RowW-1:0]   outer_rows [3];
  logic [RowW-1:0]   cross_rows [3];
  logic [PivotW-1:0] pivot_q;
  point_t            rotated_q [$];

  localparam int AtanTab [Steps] = '{2097152, 1238021, 654136, 332050, 166669, 83416,
    41718, 20860, 10430, 5215, 2608, 1304, 652, 326, 163, 81};

  function automatic int clamp_trig(int v);
    if (v > 16384) return 16384;
    if (v < -16384) return -16384;
    return v;
  endfunction

  function automatic void trig_of(input logic [AngleW-1:0] ang, output int cs, output int sn);
    logic [AngleW-1:0] a;
    logic              flip;
    int                cx, cy, cz, xs, ys;
    a = ang;
    flip = (a[15:14] == 2'b01) || (a[15:14] == 2'b10);
    if (flip) a = a - 16'h8000;
    cx = 39797;
    cy = 0;
    cz = int'($signed(a)) * 256;
    for (int i = 0; i < Steps; i++) begin
      xs = cx >>> i;
      ys = cy >>> i;
      if (cz >= 0) begin
        cx -= ys; cy += xs; cz -= AtanTab[i];
      end else begin
        cx += ys; cy -= xs; cz += AtanTab[i];
      end
    end
    cs = clamp_trig((cx + 2) >>> 2);
    sn = clamp_trig((cy + 2) >>> 2);
    if (flip) begin
      cs = -cs; sn = -sn;
    end
  endfunction

  function automatic point_t rotate_point(point_t p, logic [AngleW-1:0] ang);
    longint piv [3], d [3], b, e, sum, res;
    int     cs, sn;
    point_t r;
    trig_of(ang, cs, sn);
    for (int k = 0; k < 3; k++)
      piv[k] = longint'($signed(pivot_q[20*k +: 20]));
    d[0] = longint'(p.x) - piv[0];
    d[1] = longint'(p.y) - piv[1];
    d[2] = longint'(p.z) - piv[2];
    for (int row = 0; row < 3; row++) begin
      b = 0; e = 0;
      for (int k = 0; k < 3; k++) begin
        b += longint'($signed(outer_rows[row][16*k +: 16])) * d[k];
        e += longint'($signed(cross_rows[row][16*k +: 16])) * d[k];
      end
      sum = longint'(cs) * d[row] * 16384 + longint'(16384 - cs) * b + longint'(sn) * e;
      res = ((sum + (64'sd1 <<< 27)) >>> 28) + piv[row];
      if (res > 524287) res = 524287;
      if (res < -524288) res = -524288;
      case (row)
        0: r.x = res[19:0];
        1: r.y = res[19:0];
        default: r.z = res[19:0];
      endcase
    end
    return r;
  endfunction

  assign pending_o = rotated_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    point_t exp_p;
    int     errs;
    errs = 0;
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        outer_rows[i] <= '0; cross_rows[i] <= '0;
      end
      pivot_q <= '0;
      fail_count_o <= 0;
      rotated_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          RegOuter0: outer_rows[0] <= cfg_wdata_i[RowW-1:0];
          RegOuter1: outer_rows[1] <= cfg_wdata_i[RowW-1:0];
          RegOuter2: outer_rows[2] <= cfg_wdata_i[RowW-1:0];
          RegCross0: cross_rows[0] <= cfg_wdata_i[RowW-1:0];
          RegCross1: cross_rows[1] <= cfg_wdata_i[RowW-1:0];
          RegCross2: cross_rows[2] <= cfg_wdata_i[RowW-1:0];
          RegPivot:  pivot_q <= cfg_wdata_i[PivotW-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i)
        rotated_q.push_back(rotate_point('{point_x_i, point_y_i, point_z_i}, turn_angle_i));
      if (out_valid_i && out_ready_i) begin
        if (rotated_q.size() == 0) begin
          $error("unexpected result x=%0d y=%0d z=%0d", rotated_x_i, rotated_y_i, rotated_z_i);
          errs++;
        end else begin
          exp_p = rotated_q.pop_front();
          if (exp_p.x !== rotated_x_i) begin
            $error("rotated_x expected %0d actual %0d", exp_p.x, rotated_x_i);
            errs++;
          end
          if (exp_p.y !== rotated_y_i) begin
            $error("rotated_y expected %0d actual %0d", exp_p.y, rotated_y_i);
            errs++;
          end
          if (exp_p.z !== rotated_z_i) begin
            $error("rotated_z expected %0d actual %0d", exp_p.z, rotated_z_i);
            errs++;
          end
        end
      end
      if (errs != 0)
        fail_count_o <= fail_count_o + errs;
    end
  end

endmodule

@@ tb/tb_axis_rotation_of_point.sv @@
// ----------------------------------------------------------------------------
// tb_axis_rotation_of_point
// stimulus and verdict for the point rotation pipeline
// ----------------------------------------------------------------------------
// Several axis/pivot settings are loaded while the pipeline is idle; each phase
// pushes directed corner points, then random points and angles, with random
// idle cycles on both channels. The checker predicts and compares.
`timescale 1ns / 1ps

module tb_axis_rotation_of_point;
  import aro_pkg::*;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]       cfg_index_i = '0;
  logic [CfgW-1:0]          cfg_wdata_i = '0;
  logic                     in_valid_i = 1'b0;
  logic                     in_ready_o;
  logic signed [CoordW-1:0] point_x_i = '0;
  logic signed [CoordW-1:0] point_y_i = '0;
  logic signed [CoordW-1:0] point_z_i = '0;
  logic [AngleW-1:0]        turn_angle_i = '0;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  logic signed [CoordW-1:0] rotated_x_o, rotated_y_o, rotated_z_o;
  int                       fail_count, pending;
  int                       cycle_count = 0;
  bit                       steady_phase = 1'b0;   // no idling at all while set

  localparam int CycleLimit = 400000;

  always #5 clk_i = ~clk_i;

  axis_rotation_of_point dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_o, .point_x_i, .point_y_i, .point_z_i, .turn_angle_i,
    .out_valid_o, .out_ready_i, .rotated_x_o, .rotated_y_o, .rotated_z_o
  );

  aro_checker checker_i (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_i(in_ready_o), .point_x_i, .point_y_i, .point_z_i,
    .turn_angle_i, .out_valid_i(out_valid_o), .out_ready_i,
    .rotated_x_i(rotated_x_o), .rotated_y_i(rotated_y_o), .rotated_z_i(rotated_z_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // receiver stalls at random (ready drawn low with 20 percent odds), except during the steady stretch
  always @(posedge clk_i) begin
    out_ready_i <= steady_phase || ($urandom_range(99) >= 20);
  end

  // one register write, then the port goes quiet
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // send one transaction, holding it until accepted
  task automatic send_point(logic [19:0] px, logic [19:0] py, logic [19:0] pz,
                            logic [15:0] ang);
    while (!steady_phase && $urandom_range(99) < 20) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    point_x_i <= px;
    point_y_i <= py;
    point_z_i <= pz;
    turn_angle_i <= ang;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic drain_pipeline();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (Depth + 5) @(posedge clk_i);
  endtask

  // pack one Q2.14 row
  function automatic logic [CfgW-1:0] row_of(logic [15:0] a, logic [15:0] b, logic [15:0] c);
    return {12'h0, c, b, a};
  endfunction

  // random coordinate, mostly moderate, sometimes full range
  function automatic logic [19:0] rand_coord();
    if ($urandom_range(3) == 0) return 20'($urandom);
    return 20'($signed($urandom_range(40000)) - 20000);
  endfunction

  initial begin
    logic [15:0] angles [8];
    logic [19:0] corners [4];
    angles  = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'h3FFF, 16'h7FFF, 16'hFFFF, 16'h2000};
    corners = '{20'h7FFFF, 20'h80000, 20'h00000, 20'hFFFFF};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: ;  // registers at reset: zero matrices, pivot at origin
        1: begin  // z axis through origin
          write_reg(RegOuter0, '0);
          write_reg(RegOuter1, '0);
          write_reg(RegOuter2, row_of(0, 0, 16'd16384));
          write_reg(RegCross0, row_of(0, -16'sd16384, 0));
          write_reg(RegCross1, row_of(16'd16384, 0, 0));
          write_reg(RegCross2, '0);
          write_reg(RegPivot, '0);
        end
        2: begin  // extreme entries, extreme pivot, junk high bits
          write_reg(RegOuter0, {12'hFFF, 16'h7FFF, 16'h8000, 16'h7FFF});
          write_reg(RegOuter1, row_of(16'h8000, 16'h8000, 16'h8000));
          write_reg(RegOuter2, row_of(16'h7FFF, 16'h7FFF, 16'h7FFF));
          write_reg(RegCross0, row_of(16'h8000, 16'h7FFF, 16'h8000));
          write_reg(RegCross1, row_of(16'h7FFF, 16'h8000, 16'h7FFF));
          write_reg(RegCross2, row_of(16'hFFFF, 16'h0001, 16'h8000));
          write_reg(RegPivot, {20'h80000, 20'h7FFFF, 20'h80000});
          write_reg(3'd7, '1);  // index beyond the list is dropped
        end
        default: begin  // random axis settings and pivot
          for (int r = 0; r < 6; r++)
            write_reg(CfgIdxW'(r), CfgW'({$urandom, $urandom}));
          write_reg(RegPivot, {rand_coord(), rand_coord(), rand_coord()});
        end
      endcase

      // directed corners: every coordinate extreme against every quadrant angle
      for (int i = 0; i < 4; i++)
        for (int j = 0; j < 4; j++)
          send_point(corners[i], corners[j], corners[(i + j) % 4], angles[(i * 4 + j) % 8]);
      send_point(20'h12345, 20'hEDCBA, 20'h00100, 16'h1000);

      steady_phase = (phase == 3);
      for (int n = 0; n < 260; n++)
        send_point(rand_coord(), rand_coord(), rand_coord(), 16'($urandom));
      steady_phase = 1'b0;
      drain_pipeline();
    end

    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
